@@ rtl/rlcs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// RGB LED chain serializer package
// Shared constants, codes and structs of the one-wire pixel data encoder.
// ----------------------------------------------------------------------------
package rlcs_pkg;

  // Number of RGB pixels in the chain and derived widths.
  localparam int unsigned PIXEL_COUNT = 8;
  localparam int unsigned PIX_W       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned RGB_W       = 3 * BYTE_W;
  localparam int unsigned CHAN_W      = 2;
  localparam int unsigned BIT_W       = 3;
  localparam int unsigned TICK_W      = 6;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [PIX_W-1:0] LAST_PIX  = PIX_W'(PIXEL_COUNT - 1);
  localparam logic [BIT_W-1:0] LAST_BIT  = BIT_W'(7);

  // Color channel within one pixel, in the order they go out on the line.
  localparam logic [CHAN_W-1:0] CHAN_RED   = 2'd0;
  localparam logic [CHAN_W-1:0] CHAN_GREEN = 2'd1;
  localparam logic [CHAN_W-1:0] CHAN_BLUE  = 2'd2;

  // Timing register reset values.
  localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 6'd4;
  localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 6'd16;
  localparam logic [TICK_W-1:0] BIT_TICKS_RST = 6'd21;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_PIXEL = 2'd0,
    CMD_SHOW      = 2'd1,
    CMD_TICK      = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_HIGH = 2'd0,
    CFG_ONE_HIGH  = 2'd1,
    CFG_BIT_TICKS = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SEND = 1'b1
  } state_e;

  // Write request into the pixel register file.
  typedef struct packed {
    logic             en;
    logic [PIX_W-1:0] pix;
    logic [RGB_W-1:0] rgb;
  } pix_wr_t;

  // Result of one transaction.
  typedef struct packed {
    logic line_level;
    logic busy;
    logic frame_done;
  } wave_res_t;

endpackage : rlcs_pkg
`default_nettype wire

@@ rtl/rlcs_pixel_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// RGB LED chain serializer pixel store
// One 24-bit row per pixel, written whole, read through a registered port.
// ----------------------------------------------------------------------------
module rlcs_pixel_store
  import rlcs_pkg::*;
(
  input  logic              clk_i,
  input  pix_wr_t           wr_i,
  input  logic [PIX_W-1:0]  rd_pix_i,
  input  logic [CHAN_W-1:0] rd_chan_i,
  output logic [BYTE_W-1:0] rd_byte_o
);

  // Contents are undefined until written, so there is no reset here.
  logic [RGB_W-1:0]  rows_q [PIXEL_COUNT];
  logic [RGB_W-1:0]  rd_row_q;
  logic [CHAN_W-1:0] rd_chan_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      rows_q[wr_i.pix] <= wr_i.rgb;
    end
    // A row written in the same cycle is passed straight to the read port.
    if (wr_i.en && (wr_i.pix == rd_pix_i)) begin
      rd_row_q <= wr_i.rgb;
    end else begin
      rd_row_q <= rows_q[rd_pix_i];
    end
    rd_chan_q <= rd_chan_i;
  end

  always_comb begin
    unique case (rd_chan_q)
      CHAN_RED:   rd_byte_o = rd_row_q[3*BYTE_W-1:2*BYTE_W];
      CHAN_GREEN: rd_byte_o = rd_row_q[2*BYTE_W-1:BYTE_W];
      CHAN_BLUE:  rd_byte_o = rd_row_q[BYTE_W-1:0];
      default:    rd_byte_o = '0;
    endcase
  end

endmodule : rlcs_pixel_store
`default_nettype wire

@@ rtl/rlcs_bit_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// RGB LED chain serializer bit engine
// Frame sequencer: byte, bit and tick counters and the line level decision.
// ----------------------------------------------------------------------------
module rlcs_bit_engine
  import rlcs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  cmd_e              cmd_i,
  input  logic [IDX_W-1:0]  pixel_index_i,
  input  logic [RGB_W-1:0]  rgb_i,
  input  logic [TICK_W-1:0] zero_high_i,
  input  logic [TICK_W-1:0] one_high_i,
  input  logic [TICK_W-1:0] bit_ticks_i,
  input  logic [BYTE_W-1:0] rd_byte_i,
  output logic [PIX_W-1:0]  rd_pix_o,
  output logic [CHAN_W-1:0] rd_chan_o,
  output pix_wr_t           wr_o,
  output wave_res_t         res_o
);

  state_e              state_q, state_d;
  logic [PIX_W-1:0]    pix_q, pix_d;
  logic [CHAN_W-1:0]   chan_q, chan_d;
  logic [BIT_W-1:0]    bit_q, bit_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic [BYTE_W-1:0]   shift_q, shift_d;

  logic [PIX_W-1:0]    nxt_pix;
  logic [CHAN_W-1:0]   nxt_chan;
  logic                last_byte;
  logic [TICK_W-1:0]   high_ticks;
  logic [TICK_W-1:0]   tick_inc;
  logic                bit_end;
  logic                idx_ok;

  // Whether the current byte is the last one, and the position of the byte after it.
  assign last_byte = (pix_q == LAST_PIX) && (chan_q == CHAN_BLUE);
  assign nxt_chan  = (chan_q == CHAN_BLUE) ? CHAN_RED : chan_q + 1'b1;
  assign nxt_pix   = (chan_q == CHAN_BLUE) ? pix_q + 1'b1 : pix_q;

  // A show starts at byte zero; during a frame the next byte is prefetched
  // through the registered store port, and the last byte points back at byte
  // zero so that it is ready for the next show.
  assign rd_pix_o  = ((state_q == ST_IDLE) || last_byte) ? '0 : nxt_pix;
  assign rd_chan_o = (state_q == ST_IDLE) ? CHAN_RED : nxt_chan;

  assign high_ticks = shift_q[BYTE_W-1] ? one_high_i : zero_high_i;
  assign tick_inc   = tick_q + 1'b1;
  assign bit_end    = (tick_inc >= bit_ticks_i) || (tick_inc == '0);
  assign idx_ok     = ({1'b0, pixel_index_i} < (IDX_W + 1)'(PIXEL_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pix_q   <= '0;
      chan_q  <= CHAN_RED;
      bit_q   <= '0;
      tick_q  <= '0;
      shift_q <= '0;
    end else begin
      state_q <= state_d;
      pix_q   <= pix_d;
      chan_q  <= chan_d;
      bit_q   <= bit_d;
      tick_q  <= tick_d;
      shift_q <= shift_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pix_d   = pix_q;
    chan_d  = chan_q;
    bit_d   = bit_q;
    tick_d  = tick_q;
    shift_d = shift_q;
    wr_o.en  = 1'b0;
    wr_o.pix = pixel_index_i[PIX_W-1:0];
    wr_o.rgb = rgb_i;
    res_o.line_level = 1'b0;
    res_o.busy       = (state_q == ST_SEND);
    res_o.frame_done = 1'b0;

    if (step_i) begin
      unique case (cmd_i)
        CMD_SET_PIXEL: begin
          wr_o.en = (state_q == ST_IDLE) && idx_ok;
        end
        CMD_SHOW: begin
          res_o.busy = 1'b1;
          if (state_q == ST_IDLE) begin
            state_d = ST_SEND;
            pix_d   = '0;
            chan_d  = CHAN_RED;
            bit_d   = '0;
            tick_d  = '0;
            shift_d = rd_byte_i;
          end
        end
        CMD_TICK: begin
          if (state_q == ST_SEND) begin
            res_o.line_level = (tick_q < high_ticks);
            if (bit_end) begin
              tick_d = '0;
              if (bit_q == LAST_BIT) begin
                bit_d = '0;
                if (last_byte) begin
                  state_d = ST_IDLE;
                  pix_d   = '0;
                  chan_d  = CHAN_RED;
                  shift_d = '0;
                  res_o.frame_done = 1'b1;
                end else begin
                  pix_d   = nxt_pix;
                  chan_d  = nxt_chan;
                  shift_d = rd_byte_i;
                end
              end else begin
                bit_d   = bit_q + 1'b1;
                shift_d = {shift_q[BYTE_W-2:0], 1'b0};
              end
            end else begin
              tick_d = tick_inc;
            end
          end
        end
        default: begin
          // Unused command code: no effect.
        end
      endcase
    end
  end

endmodule : rlcs_bit_engine
`default_nettype wire

@@ rtl/rgb_led_chain_serializer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// RGB LED chain serializer top level
// One-wire LED data encoder with pixel store, timing registers and handshake.
// ----------------------------------------------------------------------------
// The block holds one frame of eight RGB pixels and turns it into the pulse
// waveform of a one-wire LED chain. Each input transaction is a set-pixel, a
// show or a tick command, and each one returns exactly one result transaction
// carrying the line level, the busy flag and the frame-done flag. The block
// accepts one transaction per clock cycle while in_stall_o is low; each
// passes through an input register and then a result register, which
// presents its result on the output until it is taken. When the output side
// stalls, the result register holds its value and the input side stalls as
// soon as the input register is also occupied. A frame of 24 bytes takes
// 24 * 8 * bit_ticks tick transactions, one tick per bit when bit_ticks is
// 0 or 1; set-pixel and show commands are ignored while a frame is in
// flight. Timing registers are to be written through the plain write port
// only while no transaction is in the pipeline; the block itself does not
// enforce this. A change made during a frame applies from the next tick on.
module rgb_led_chain_serializer_top
  import rlcs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TICK_W-1:0]    cfg_data_i,
  // Input channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [IDX_W-1:0]     pixel_index_i,
  input  logic [BYTE_W-1:0]    red_i,
  input  logic [BYTE_W-1:0]    green_i,
  input  logic [BYTE_W-1:0]    blue_i,
  // Output channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 line_level_o,
  output logic                 busy_res_o,
  output logic                 frame_done_o
);

  // Timing registers.
  logic [TICK_W-1:0] zero_high_q, one_high_q, bit_ticks_q;

  // Input register stage.
  logic              in_vld_q;
  cmd_e              cmd_q;
  logic [IDX_W-1:0]  idx_q;
  logic [RGB_W-1:0]  rgb_q;

  // Result register stage.
  logic              out_vld_q;
  wave_res_t         res_q;

  logic              out_free;
  logic              advance;
  logic              in_accept;
  wave_res_t         res_d;
  pix_wr_t           pix_wr;
  logic [PIX_W-1:0]  rd_pix;
  logic [CHAN_W-1:0] rd_chan;
  logic [BYTE_W-1:0] rd_byte;

  // The result register can take a new value when it is empty or being drained.
  assign out_free  = !out_vld_q || !out_stall_i;
  // The transaction in the input register is processed when its result fits.
  assign advance   = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_high_q <= ZERO_HIGH_RST;
      one_high_q  <= ONE_HIGH_RST;
      bit_ticks_q <= BIT_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ZERO_HIGH: zero_high_q <= cfg_data_i;
        CFG_ONE_HIGH:  one_high_q  <= cfg_data_i;
        CFG_BIT_TICKS: bit_ticks_q <= cfg_data_i;
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= cmd_e'(command_i);
      idx_q <= pixel_index_i;
      rgb_q <= {red_i, green_i, blue_i};
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  rlcs_pixel_store u_store (
    .clk_i     (clk_i),
    .wr_i      (pix_wr),
    .rd_pix_i  (rd_pix),
    .rd_chan_i (rd_chan),
    .rd_byte_o (rd_byte)
  );

  rlcs_bit_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .cmd_i         (cmd_q),
    .pixel_index_i (idx_q),
    .rgb_i         (rgb_q),
    .zero_high_i   (zero_high_q),
    .one_high_i    (one_high_q),
    .bit_ticks_i   (bit_ticks_q),
    .rd_byte_i     (rd_byte),
    .rd_pix_o      (rd_pix),
    .rd_chan_o     (rd_chan),
    .wr_o          (pix_wr),
    .res_o         (res_d)
  );

  assign out_valid_o  = out_vld_q;
  assign line_level_o = res_q.line_level;
  assign busy_res_o   = res_q.busy;
  assign frame_done_o = res_q.frame_done;

  // A driven line or an end of frame can only be reported while sending.
  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (res_q.frame_done || res_q.line_level) |-> res_q.busy)
    else $error("frame_done or line_level reported without busy");

  // The input side is held back only when both stages are occupied.
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q)
    else $error("input stalled while a stage was free");

  // A processed transaction always lands in the result register.
  a_advance_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("processed transaction lost its result");

  // No pixel write can happen while a frame is in flight.
  a_no_write_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_wr.en |-> !res_d.busy)
    else $error("pixel store written during a frame");

endmodule : rgb_led_chain_serializer_top
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED chain serializer testbench
// Sends set-pixel, show and tick transactions into the one-wire encoder,
// predicts every result transaction from its own model of the frame shifter
// and checks line level, busy and frame-done flags in order of arrival.
// ----------------------------------------------------------------------------
module tb_top;
  import rlcs_pkg::*;

  localparam int unsigned FRAME_BYTES  = PIXEL_COUNT * 3;
  localparam int unsigned CYCLE_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_LEN     = 200;
  localparam int unsigned MAX_PRINTS   = 40;
  localparam int unsigned RESET_TICKS  = 90;

  // The fourth command code has no meaning and must be ignored by the block.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Clock, reset and every input of the block start at a known value.
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = CFG_ZERO_HIGH;
  logic [TICK_W-1:0]    cfg_data_i    = '0;
  logic                 in_valid_i    = 1'b0;
  logic [CMD_W-1:0]     command_i     = CMD_TICK;
  logic [IDX_W-1:0]     pixel_index_i = '0;
  logic [BYTE_W-1:0]    red_i         = '0;
  logic [BYTE_W-1:0]    green_i       = '0;
  logic [BYTE_W-1:0]    blue_i        = '0;
  logic                 out_stall_i   = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic                 line_level_o;
  logic                 busy_res_o;
  logic                 frame_done_o;

  // Shadow copy of the encoder: pixel bytes, shifter state and timing.
  logic [BYTE_W-1:0] frame_mem [FRAME_BYTES];
  logic              sending_q;
  int unsigned       byte_ptr;
  logic [BIT_W-1:0]  bit_pos;
  logic [TICK_W-1:0] tick_cnt;
  logic [BYTE_W-1:0] shift_reg;
  logic [TICK_W-1:0] zero_high;
  logic [TICK_W-1:0] one_high;
  logic [TICK_W-1:0] bit_len;

  // Predicted results, oldest first.
  wave_res_t line_results_q [$];

  // Run bookkeeping.
  bit          no_idle       = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned error_cnt     = 0;
  int unsigned txn_cnt       = 0;
  int unsigned useful_cnt    = 0;
  int unsigned result_cnt    = 0;
  int unsigned frames_seen   = 0;
  int unsigned in_stall_cnt  = 0;
  int unsigned timing_sets   = 0;

  rgb_led_chain_serializer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .pixel_index_i (pixel_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .line_level_o  (line_level_o),
    .busy_res_o    (busy_res_o),
    .frame_done_o  (frame_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_cnt, line_results_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic want, input logic got);
    error_cnt++;
    if (error_cnt <= MAX_PRINTS) begin
      $display("Mismatch at cycle %0d: %s should be %0b, is %0b", cycle_cnt, what, want, got);
    end
  endtask

  // Advance the shadow encoder by one accepted transaction. The effect flag
  // tells whether the transaction did anything, so ignored ones are not
  // counted as useful stimulus.
  task automatic encode_step(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] r, input logic [BYTE_W-1:0] g,
                             input logic [BYTE_W-1:0] b, output wave_res_t res,
                             output bit effect);
    logic [TICK_W-1:0] high_len;
    res    = '0;
    effect = 1'b0;
    case (cmd)
      CMD_SET_PIXEL: begin
        if (!sending_q && idx < PIXEL_COUNT) begin
          frame_mem[idx * 3]     = r;
          frame_mem[idx * 3 + 1] = g;
          frame_mem[idx * 3 + 2] = b;
          effect                 = 1'b1;
        end
        res.busy = sending_q;
      end
      CMD_SHOW: begin
        if (!sending_q) begin
          sending_q = 1'b1;
          byte_ptr  = 0;
          bit_pos   = '0;
          tick_cnt  = '0;
          shift_reg = frame_mem[0];
          effect    = 1'b1;
        end
        res.busy = 1'b1;
      end
      CMD_TICK: begin
        if (sending_q) begin
          effect         = 1'b1;
          high_len       = shift_reg[BYTE_W-1] ? one_high : zero_high;
          res.busy       = 1'b1;
          res.line_level = (tick_cnt < high_len);
          tick_cnt       = tick_cnt + 1'b1;
          // A bit ends at the programmed length or when the counter wraps; a
          // length of 0 or 1 makes every bit a single tick.
          if (tick_cnt >= bit_len || tick_cnt == '0) begin
            tick_cnt = '0;
            if (bit_pos == LAST_BIT) begin
              bit_pos = '0;
              byte_ptr++;
              if (byte_ptr >= FRAME_BYTES) begin
                byte_ptr       = 0;
                sending_q      = 1'b0;
                shift_reg      = '0;
                res.frame_done = 1'b1;
              end else begin
                shift_reg = frame_mem[byte_ptr];
              end
            end else begin
              bit_pos++;
              shift_reg = shift_reg << 1;
            end
          end
        end
      end
      default: begin
        res.busy = sending_q;
      end
    endcase
  endtask

  // Offer one transaction, possibly after a random gap, and record its
  // predicted result at the edge where it is accepted.
  task automatic send_txn(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                          input logic [BYTE_W-1:0] r, input logic [BYTE_W-1:0] g,
                          input logic [BYTE_W-1:0] b);
    wave_res_t res;
    bit        effect;
    while (!no_idle && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    pixel_index_i <= idx;
    red_i         <= r;
    green_i       <= g;
    blue_i        <= b;
    @(posedge clk_i);
    while (in_stall_o) begin
      in_stall_cnt++;
      @(posedge clk_i);
    end
    encode_step(cmd, idx, r, g, b, res, effect);
    line_results_q.push_back(res);
    txn_cnt++;
    if (effect) begin
      useful_cnt++;
    end
  endtask

  // A tick carries random bytes in its unused fields.
  task automatic send_tick();
    send_txn(CMD_TICK, IDX_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
             BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
  endtask

  task automatic finish_frame();
    while (sending_q) begin
      send_tick();
    end
  endtask

  // Stop offering, let every pending result arrive, then keep waiting
  // so that any stray result would show up.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (line_results_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all three timing registers on consecutive edges while the
  // pipeline is empty.
  task automatic load_timing(input logic [TICK_W-1:0] zero_val,
                             input logic [TICK_W-1:0] one_val,
                             input logic [TICK_W-1:0] bit_val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ZERO_HIGH;
    cfg_data_i  <= zero_val;
    @(posedge clk_i);
    cfg_index_i <= CFG_ONE_HIGH;
    cfg_data_i  <= one_val;
    @(posedge clk_i);
    cfg_index_i <= CFG_BIT_TICKS;
    cfg_data_i  <= bit_val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    zero_high = zero_val;
    one_high  = one_val;
    bit_len   = bit_val;
    timing_sets++;
  endtask

  // Random traffic shaped like real use: while idle, pixel updates and a
  // show come quickly; while a frame is out, nearly everything is a tick,
  // with some set-pixel, show and unused commands that must be ignored.
  task automatic random_traffic(input int unsigned n, input bit drain);
    int unsigned       start;
    int unsigned       pick;
    logic [IDX_W-1:0]  idx;
    logic [CMD_W-1:0]  noise_cmd;
    start = useful_cnt;
    while (useful_cnt - start < n) begin
      pick = $urandom_range(99);
      if (sending_q) begin
        if (pick < 92) begin
          send_tick();
        end else begin
          case ($urandom_range(2))
            0:       noise_cmd = CMD_SET_PIXEL;
            1:       noise_cmd = CMD_SHOW;
            default: noise_cmd = CMD_UNUSED;
          endcase
          send_txn(noise_cmd, IDX_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                   BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
        end
      end else begin
        if ($urandom_range(3) == 0) begin
          idx = IDX_W'($urandom_range(255));
        end else begin
          idx = IDX_W'($urandom_range(PIXEL_COUNT - 1));
        end
        if (pick < 45) begin
          send_txn(CMD_SET_PIXEL, idx, BYTE_W'($urandom_range(255)),
                   BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
        end else if (pick < 75) begin
          send_txn(CMD_SHOW, idx, BYTE_W'($urandom_range(255)),
                   BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
        end else if (pick < 90) begin
          send_tick();
        end else begin
          send_txn(CMD_UNUSED, idx, BYTE_W'($urandom_range(255)),
                   BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
        end
      end
    end
    if (drain) begin
      finish_frame();
    end
  endtask

  // Directed checks. Every pixel is written first, so no show ever sends a
  // byte that was never stored. The first bits go out at the reset timing;
  // then the timing is cut to one tick per bit, with a zero high time and a
  // one high time equal to the bit time, so the frame ends quickly.
  task automatic test_directed();
    int unsigned p;
    send_txn(CMD_SET_PIXEL, 8'd0, 8'hA5, 8'hFF, 8'hFF);
    send_txn(CMD_SET_PIXEL, 8'd1, 8'h00, 8'h00, 8'h00);
    send_txn(CMD_SET_PIXEL, 8'd2, 8'h80, 8'h01, 8'hAA);
    send_txn(CMD_SET_PIXEL, 8'd3, 8'h55, 8'h7F, 8'hFE);
    for (p = 4; p < PIXEL_COUNT; p++) begin
      send_txn(CMD_SET_PIXEL, IDX_W'(p), BYTE_W'($urandom_range(255)),
               BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
    end
    // Indices at and beyond the end of the chain are dropped.
    send_txn(CMD_SET_PIXEL, IDX_W'(PIXEL_COUNT), 8'h11, 8'h22, 8'h33);
    send_txn(CMD_SET_PIXEL, 8'hFF, 8'h44, 8'h55, 8'h66);
    // Unused command and a tick with no frame in flight change nothing.
    send_txn(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_tick();
    send_txn(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
    // While busy, writes, a second show and the unused code are ignored.
    send_txn(CMD_SET_PIXEL, 8'd0, 8'h12, 8'h34, 8'h56);
    send_txn(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
    send_txn(CMD_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00);
    repeat (RESET_TICKS) send_tick();
    wait_quiet();
    load_timing(6'd0, 6'd1, 6'd1);
    finish_frame();
    send_tick();
    wait_quiet();
  endtask

  // Walk the timing registers through more corners: a high time equal to
  // the bit time, and a bit time of 0 with one high time past the bit and
  // the other zero.
  task automatic test_timing_extremes();
    logic [TICK_W-1:0] zero_tab [2] = '{6'd1, 6'd63};
    logic [TICK_W-1:0] one_tab  [2] = '{6'd2, 6'd0};
    logic [TICK_W-1:0] bit_tab  [2] = '{6'd2, 6'd0};
    int unsigned       k;
    for (k = 0; k < 2; k++) begin
      load_timing(zero_tab[k], one_tab[k], bit_tab[k]);
      random_traffic(30, 1'b1);
      wait_quiet();
    end
  endtask

  // The receiver holds off for a long stretch while a frame keeps being
  // offered, so the block's pipeline fills and it stalls its input side.
  task automatic test_backpressure();
    load_timing(6'd1, 6'd63, 6'd1);
    hold_requests++;
    send_txn(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
    finish_frame();
    wait_quiet();
  endtask

  // Back-to-back traffic on both sides with no gaps at all; any frame still in
  // flight is left for the next test.
  task automatic test_no_idle();
    load_timing(6'd3, 6'd7, 6'd9);
    no_idle = 1'b1;
    random_traffic(100, 1'b0);
    no_idle = 1'b0;
    wait_quiet();
  endtask

  // Longest bit time with full-length one-bit pulses, switched in while a frame
  // may still be in flight; a frame is not finished since a whole one would
  // take far longer than the rest of the run.
  task automatic test_slow_bits();
    load_timing(6'd30, 6'd63, 6'd63);
    random_traffic(120, 1'b0);
  endtask

  // Receiver side: checks each accepted result against the oldest
  // prediction, then picks the stall for the next cycle. A hold-off request
  // from a test task is counted down here on every edge.
  task automatic check_result();
    wave_res_t want;
    if (line_results_q.size() == 0) begin
      report_mismatch("result with nothing pending, frame_done", 1'b0, frame_done_o);
    end else begin
      want = line_results_q.pop_front();
      result_cnt++;
      if (line_level_o !== want.line_level) begin
        report_mismatch("line_level", want.line_level, line_level_o);
      end
      if (busy_res_o !== want.busy) begin
        report_mismatch("busy_res", want.busy, busy_res_o);
      end
      if (frame_done_o !== want.frame_done) begin
        report_mismatch("frame_done", want.frame_done, frame_done_o);
      end else if (want.frame_done) begin
        frames_seen++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        check_result();
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (!no_idle && $urandom_range(99) < 11);
      end
    end
  end

  initial begin
    // Shadow state after reset; pixel bytes are undefined but never read
    // before they are written.
    for (int i = 0; i < FRAME_BYTES; i++) begin
      frame_mem[i] = '0;
    end
    sending_q = 1'b0;
    byte_ptr  = 0;
    bit_pos   = '0;
    tick_cnt  = '0;
    shift_reg = '0;
    zero_high = ZERO_HIGH_RST;
    one_high  = ONE_HIGH_RST;
    bit_len   = BIT_TICKS_RST;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    test_timing_extremes();
    test_backpressure();
    test_no_idle();
    test_slow_bits();
    wait_quiet();

    $display("Ran %0d transactions (%0d with effect), checked %0d results, %0d frames.",
             txn_cnt, useful_cnt, result_cnt, frames_seen);
    $display("Used %0d timing settings plus reset timing; input stalled %0d cycles.",
             timing_sets, in_stall_cnt);
    if (error_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ rgb_led_chain_serializer_top.f @@
rtl/rlcs_pkg.sv
rtl/rlcs_pixel_store.sv
rtl/rlcs_bit_engine.sv
rtl/rgb_led_chain_serializer_top.sv
test/tb_top.sv
